// ===== rtl/lpd_pkg.sv =====
// Package for the length-prefixed deframer: header constants, phase enum, result type.
// No dependencies; used by every other file of the block.
package lpd_pkg;

  localparam int unsigned SizeW = 22;
  localparam int unsigned ByteW = 8;
  localparam int unsigned HdrShift = 7;

  localparam logic [ByteW-1:0] HdrMore    = 8'h80;
  localparam logic [ByteW-1:0] HdrDeflate = 8'h40;
  localparam logic [ByteW-1:0] HdrMask7   = 8'h7f;
  localparam logic [ByteW-1:0] HdrMask6   = 8'h3f;

  typedef enum logic [1:0] {
    PH_FIRST   = 2'd0,
    PH_SECOND  = 2'd1,
    PH_THIRD   = 2'd2,
    PH_PAYLOAD = 2'd3
  } phase_e;

  typedef struct packed {
    logic [ByteW-1:0] payload_byte;
    logic             coding;
    logic [SizeW-1:0] message_size;
    logic             is_last;
    logic             empty_message;
  } lpd_result_t;

endpackage

// ===== rtl/lpd_if.sv =====
// Valid/ready channel interfaces of the deframer: received bytes in, results out.
// Depends on lpd_pkg for field widths.
interface lpd_in_if;
  logic                     valid;
  logic                     ready;
  logic [lpd_pkg::ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface lpd_out_if;
  logic                     valid;
  logic                     ready;
  logic [lpd_pkg::ByteW-1:0] payload_byte;
  logic                     coding;
  logic [lpd_pkg::SizeW-1:0] message_size;
  logic                     is_last;
  logic                     empty_message;

  modport source (output valid, output payload_byte, output coding, output message_size,
                  output is_last, output empty_message, input ready);
  modport sink   (input valid, input payload_byte, input coding, input message_size,
                  input is_last, input empty_message, output ready);
endinterface

// ===== rtl/lpd_in_reg.sv =====
// Input register stage: captures one received byte per transaction.
// Depends on lpd_pkg and lpd_in_if.
module lpd_in_reg (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  lpd_in_if.sink                    rx_i,
  input  logic                      take_i,
  output logic                      valid_o,
  output logic [lpd_pkg::ByteW-1:0] byte_o
);

  logic                      valid_q, valid_d;
  logic [lpd_pkg::ByteW-1:0] byte_q;
  logic                      load;

  assign rx_i.ready = !valid_q || take_i;
  assign load       = rx_i.valid && rx_i.ready;
  assign valid_d    = rx_i.ready ? rx_i.valid : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= rx_i.rx_byte;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

// ===== rtl/lpd_parser.sv =====
// Header parser and payload counter: consumes the registered byte and forms the result.
// Depends on lpd_pkg.
module lpd_parser (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  logic [lpd_pkg::ByteW-1:0] byte_i,
  input  logic                      slot_free_i,
  output logic                      take_o,
  output logic                      res_valid_o,
  output lpd_pkg::lpd_result_t      res_o
);

  lpd_pkg::phase_e           phase_q, phase_d;
  logic [lpd_pkg::SizeW-1:0] size_q, size_d;
  logic [lpd_pkg::SizeW-1:0] left_q, left_d;
  logic                      deflate_q, deflate_d;
  logic                      has_res;
  logic [lpd_pkg::SizeW-1:0] left_dec;
  logic [lpd_pkg::SizeW-1:0] hdr_size;
  logic                      hdr_deflate;
  logic                      hdr_done;

  assign left_dec = left_q - lpd_pkg::SizeW'(1);

  always_comb begin
    phase_d     = phase_q;
    size_d      = size_q;
    left_d      = left_q;
    deflate_d   = deflate_q;
    has_res     = 1'b0;
    hdr_done    = 1'b0;
    hdr_size    = size_q;
    hdr_deflate = deflate_q;
    res_o       = '0;
    unique case (phase_q)
      lpd_pkg::PH_FIRST: begin
        hdr_size    = lpd_pkg::SizeW'(byte_i & lpd_pkg::HdrMask7);
        hdr_deflate = 1'b0;
        if ((byte_i & lpd_pkg::HdrMore) != '0) begin
          phase_d = lpd_pkg::PH_SECOND;
        end else begin
          hdr_done = 1'b1;
        end
      end
      lpd_pkg::PH_SECOND: begin
        if ((byte_i & lpd_pkg::HdrMore) != '0) begin
          hdr_size    = size_q |
                        (lpd_pkg::SizeW'(byte_i & lpd_pkg::HdrMask7) << lpd_pkg::HdrShift);
          hdr_deflate = 1'b1;
          phase_d     = lpd_pkg::PH_THIRD;
        end else begin
          hdr_size    = size_q |
                        (lpd_pkg::SizeW'(byte_i & lpd_pkg::HdrMask6) << lpd_pkg::HdrShift);
          hdr_deflate = (byte_i & lpd_pkg::HdrDeflate) != '0;
          hdr_done    = 1'b1;
        end
      end
      lpd_pkg::PH_THIRD: begin
        hdr_size = size_q | (lpd_pkg::SizeW'(byte_i) << (2 * lpd_pkg::HdrShift));
        hdr_done = 1'b1;
      end
      lpd_pkg::PH_PAYLOAD: begin
        has_res            = 1'b1;
        left_d             = left_dec;
        res_o.payload_byte = byte_i;
        res_o.coding       = deflate_q;
        res_o.message_size = size_q;
        res_o.is_last      = left_dec == '0;
        if (left_dec == '0) begin
          phase_d = lpd_pkg::PH_FIRST;
        end
      end
      default: begin
        phase_d = lpd_pkg::PH_FIRST;
      end
    endcase

    if (phase_q != lpd_pkg::PH_PAYLOAD) begin
      size_d    = hdr_size;
      deflate_d = hdr_deflate;
    end

    if (hdr_done) begin
      if (hdr_size == '0) begin
        has_res             = 1'b1;
        res_o.coding        = hdr_deflate;
        res_o.is_last       = 1'b1;
        res_o.empty_message = 1'b1;
        left_d              = '0;
        phase_d             = lpd_pkg::PH_FIRST;
      end else begin
        left_d  = hdr_size;
        phase_d = lpd_pkg::PH_PAYLOAD;
      end
    end
  end

  assign take_o      = valid_i && (!has_res || slot_free_i);
  assign res_valid_o = take_o && has_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= lpd_pkg::PH_FIRST;
      size_q    <= '0;
      left_q    <= '0;
      deflate_q <= 1'b0;
    end else if (take_o) begin
      phase_q   <= phase_d;
      size_q    <= size_d;
      left_q    <= left_d;
      deflate_q <= deflate_d;
    end
  end

  a_payload_left_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == lpd_pkg::PH_PAYLOAD |-> left_q != '0)
    else $error("payload phase with no bytes left");

  a_last_returns_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.is_last |=> phase_q == lpd_pkg::PH_FIRST)
    else $error("last result did not return to header parsing");

  a_empty_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.empty_message |->
      res_o.message_size == '0 && res_o.payload_byte == '0 && res_o.is_last)
    else $error("empty result carries data");

  a_payload_size_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_o && phase_q == lpd_pkg::PH_PAYLOAD && !res_o.is_last |=> $stable(size_q))
    else $error("message size changed inside payload");

endmodule

// ===== rtl/lpd_out_reg.sv =====
// Result register: holds one result until the downstream side takes it.
// Depends on lpd_pkg and lpd_out_if.
module lpd_out_reg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  lpd_pkg::lpd_result_t in_data_i,
  output logic                 free_o,
  lpd_out_if.source            res_o
);

  logic                 valid_q, valid_d;
  lpd_pkg::lpd_result_t data_q;

  assign free_o  = !valid_q || res_o.ready;
  assign valid_d = in_valid_i || (valid_q && !res_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i) begin
      data_q <= in_data_i;
    end
  end

  assign res_o.valid         = valid_q;
  assign res_o.payload_byte  = data_q.payload_byte;
  assign res_o.coding        = data_q.coding;
  assign res_o.message_size  = data_q.message_size;
  assign res_o.is_last       = data_q.is_last;
  assign res_o.empty_message = data_q.empty_message;

endmodule

// ===== rtl/varlen_length_prefix_deframer_unit.sv =====
// Length-prefixed deframer: one received byte per transaction on rx_i, one result per
// payload byte or per zero-size header on res_o. Takes one byte every cycle unless a
// result is held back by res_o; the byte lands in the input register, the parser forms
// the result from it combinationally, and the result register loads it when the parser
// takes the byte. The header/count state is updated at that same edge, between the two
// registers. Header bytes of a non-empty message give no result. No clearing pass after
// reset.
// Depends on lpd_pkg, lpd_if, lpd_in_reg, lpd_parser and lpd_out_reg.
module varlen_length_prefix_deframer_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  lpd_in_if.sink    rx_i,
  lpd_out_if.source res_o
);

  logic                      s1_valid;
  logic [lpd_pkg::ByteW-1:0] s1_byte;
  logic                      take;
  logic                      slot_free;
  logic                      res_valid;
  lpd_pkg::lpd_result_t      res;

  lpd_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rx_i    (rx_i),
    .take_i  (take),
    .valid_o (s1_valid),
    .byte_o  (s1_byte)
  );

  lpd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (s1_valid),
    .byte_i      (s1_byte),
    .slot_free_i (slot_free),
    .take_o      (take),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  lpd_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (res_valid),
    .in_data_i  (res),
    .free_o     (slot_free),
    .res_o      (res_o)
  );

endmodule
